// ----- rtl/dam_pkg.sv -----
`timescale 1ns / 1ps

package dam_pkg;

	// default size of the word store
	localparam int MEM_WORDS_DEF = 100;

	// word range of the machine
	localparam logic signed [14:0] WORD_MAX = 15'sd9999;
	localparam logic signed [14:0] WORD_MIN = -15'sd9999;

	// item modes
	localparam logic [1:0] MODE_LOAD    = 2'd0;
	localparam logic [1:0] MODE_EXEC    = 2'd1;
	localparam logic [1:0] MODE_RESTART = 2'd2;

	// result status codes
	localparam logic [2:0] STS_DONE       = 3'd0;
	localparam logic [2:0] STS_EXECUTED   = 3'd1;
	localparam logic [2:0] STS_WROTE      = 3'd2;
	localparam logic [2:0] STS_HALTED     = 3'd3;
	localparam logic [2:0] STS_BAD_OP     = 3'd4;
	localparam logic [2:0] STS_PC_OVERRUN = 3'd5;
	localparam logic [2:0] STS_IGNORED    = 3'd6;

	// opcodes
	localparam logic signed [7:0] OP_READ  = 8'sd10;
	localparam logic signed [7:0] OP_WRITE = 8'sd11;
	localparam logic signed [7:0] OP_LOAD  = 8'sd20;
	localparam logic signed [7:0] OP_STORE = 8'sd21;
	localparam logic signed [7:0] OP_ADD   = 8'sd30;
	localparam logic signed [7:0] OP_HALT  = 8'sd43;

	// divide by 100 as multiply by reciprocal, exact for magnitudes up to 9999
	localparam int DIV100_MUL   = 5243;
	localparam int DIV100_SHIFT = 19;

	typedef enum logic [2:0] {
		KIND_LOAD,
		KIND_RESTART,
		KIND_IGNORE,
		KIND_OVERRUN,
		KIND_EXEC
	} kind_t;

	// controller to datapath
	typedef struct packed {
		logic  accept;
		logic  fetch;
		logic  exec;
		kind_t kind;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic running;
		logic pc_ovf;
	} sts_t;

endpackage

// ----- rtl/decimal_accumulator_machine.sv -----
`timescale 1ns / 1ps

// channel   signals                                     handshake
// --------  ------------------------------------------  ------------------------------
// item in   mode, address, value                        start high while busy is low
// result    status, out_value, program_counter,          done high for one cycle,
//           acc_value, last_opcode                       taken at the edge ending it
//
// an item is taken at the edge where start is high and busy is low
// load, restart, ignored and pc overrun beats go from idle to the commit state, which registers done
// execute beats go from idle to fetch, then to commit, which registers done: the single read port of the
//   word store is used once for the instruction and once for the operand
// the next beat may be taken in the cycle that done is high
// reset clears the store through per-word valid bits at once, no clearing pass
// the receiver cannot stall: each result is shown for exactly one cycle

module decimal_accumulator_machine import dam_pkg::*; #(
	parameter int MEM_WORDS = MEM_WORDS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         mode,
	input  logic [6:0]         address,
	input  logic signed [14:0] value,
	output logic               done,
	output logic [2:0]         status,
	output logic signed [14:0] out_value,
	output logic [6:0]         program_counter,
	output logic signed [14:0] acc_value,
	output logic signed [7:0]  last_opcode
);

	// commands from the sequencer, run state back from the datapath
	cmd_t cmd;
	sts_t sts;

	// sequencer: idle, instruction decode, commit
	dam_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// word store, accumulator, program counter and result registers
	dam_datapath #(
		.MEM_WORDS (MEM_WORDS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.address         (address),
		.value           (value),
		.sts             (sts),
		.status          (status),
		.out_value       (out_value),
		.program_counter (program_counter),
		.acc_value       (acc_value),
		.last_opcode     (last_opcode)
	);

endmodule

// ----- rtl/dam_ctrl.sv -----
`timescale 1ns / 1ps

module dam_ctrl import dam_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] mode,
	input  sts_t       sts,
	output cmd_t       cmd,
	output logic       busy,
	output logic       done
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EXEC
	} state_t;

	state_t state_q;
	kind_t  kind_q;
	kind_t  kind_d;
	logic   done_q;
	logic   accept;

	assign accept = start && (state_q == ST_IDLE);

	always_comb begin
		unique case (mode)
			MODE_LOAD:    kind_d = KIND_LOAD;
			MODE_RESTART: kind_d = KIND_RESTART;
			MODE_EXEC: begin
				if (!sts.running)
					kind_d = KIND_IGNORE;
				else if (sts.pc_ovf)
					kind_d = KIND_OVERRUN;
				else
					kind_d = KIND_EXEC;
			end
			default:      kind_d = KIND_IGNORE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= KIND_IGNORE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == ST_EXEC);
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						kind_q  <= kind_d;
						state_q <= (kind_d == KIND_EXEC) ? ST_FETCH : ST_EXEC;
					end
				end
				ST_FETCH: state_q <= ST_EXEC;
				ST_EXEC:  state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	assign cmd.accept = accept;
	assign cmd.fetch  = (state_q == ST_FETCH);
	assign cmd.exec   = (state_q == ST_EXEC);
	assign cmd.kind   = kind_q;
	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;

`ifndef SYNTHESIS
	a_exec_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (kind_d == KIND_EXEC) |-> ##3 done_q)
		else $error("execute beat did not finish in three cycles");
	a_short_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (kind_d != KIND_EXEC) |-> ##2 done_q)
		else $error("simple beat did not finish in two cycles");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("result strobe while busy");
`endif

endmodule

// ----- rtl/dam_datapath.sv -----
`timescale 1ns / 1ps

module dam_datapath import dam_pkg::*; #(
	parameter int MEM_WORDS = MEM_WORDS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  logic [6:0]         address,
	input  logic signed [14:0] value,
	output sts_t               sts,
	output logic [2:0]         status,
	output logic signed [14:0] out_value,
	output logic [6:0]         program_counter,
	output logic signed [14:0] acc_value,
	output logic signed [7:0]  last_opcode
);

	localparam int AW = $clog2(MEM_WORDS);
	localparam logic [6:0] DEPTH = 7'(MEM_WORDS);

	// word store with per-entry valid bits, unwritten entries read as zero
	logic signed [14:0] mem [MEM_WORDS];
	logic [MEM_WORDS-1:0] valid_q;
	logic signed [14:0] rd_data_q;
	logic               rd_valid_q;
	logic               rd_en;
	logic [AW-1:0]      rd_idx;
	logic               wr_en;
	logic [AW-1:0]      wr_idx;
	logic signed [14:0] wr_data;

	// architectural state
	logic [6:0]         pc_q;
	logic signed [14:0] acc_q;
	logic               run_q;
	logic signed [7:0]  op_q;
	logic [6:0]         opnd_q;
	logic               opnd_ok_q;

	// latched item
	logic [6:0]         addr_q;
	logic signed [14:0] val_q;
	logic signed [14:0] val_sat;

	// result registers
	logic [2:0]         status_q;
	logic signed [14:0] outv_q;

	// decode
	logic signed [14:0] fetch_word;
	logic               neg;
	logic [14:0]        neg_word;
	logic [13:0]        mag;
	logic [26:0]        prod;
	logic [6:0]         quo;
	logic [13:0]        quo100;
	logic [13:0]        rem14;
	logic [6:0]         rem;
	logic [7:0]         quo_x;
	logic signed [7:0]  opc;

	// execute
	logic signed [14:0] opw;
	logic signed [15:0] sum;
	logic signed [14:0] sum_sat;
	logic [6:0]         pc_d;
	logic signed [14:0] acc_d;
	logic               run_d;
	logic [2:0]         sts_d;
	logic signed [14:0] outv_d;

	always_comb begin
		if (value > WORD_MAX)
			val_sat = WORD_MAX;
		else if (value < WORD_MIN)
			val_sat = WORD_MIN;
		else
			val_sat = value;
	end

	// split fetched word into opcode and operand
	assign fetch_word = rd_valid_q ? rd_data_q : '0;
	assign neg        = fetch_word[14];
	assign neg_word   = 15'd0 - fetch_word;
	assign mag        = neg ? neg_word[13:0] : fetch_word[13:0];
	assign prod       = {13'd0, mag} * 27'(DIV100_MUL);
	assign quo        = prod[DIV100_SHIFT +: 7];
	assign quo100     = 14'({quo, 6'd0}) + 14'({quo, 5'd0}) + 14'({quo, 2'd0});
	assign rem14      = mag - quo100;
	assign rem        = rem14[6:0];
	assign quo_x      = {1'b0, quo};
	assign opc        = neg ? $signed(8'd0 - quo_x) : $signed(quo_x);

	// read port: instruction at accept, operand during fetch
	always_comb begin
		rd_en  = 1'b0;
		rd_idx = pc_q[AW-1:0];
		if (cmd.accept) begin
			rd_en  = (pc_q < DEPTH);
			rd_idx = pc_q[AW-1:0];
		end else if (cmd.fetch) begin
			rd_en  = (rem < DEPTH);
			rd_idx = rem[AW-1:0];
		end
	end

	assign opw     = (opnd_ok_q && rd_valid_q) ? rd_data_q : '0;
	assign sum     = 16'(acc_q) + 16'(opw);

	always_comb begin
		if (sum > 16'sd9999)
			sum_sat = WORD_MAX;
		else if (sum < -16'sd9999)
			sum_sat = WORD_MIN;
		else
			sum_sat = sum[14:0];
	end

	always_comb begin
		pc_d    = pc_q;
		acc_d   = acc_q;
		run_d   = run_q;
		sts_d   = STS_IGNORED;
		outv_d  = '0;
		wr_en   = 1'b0;
		wr_idx  = opnd_q[AW-1:0];
		wr_data = val_q;
		unique case (cmd.kind)
			KIND_LOAD: begin
				if (addr_q < DEPTH) begin
					wr_en  = 1'b1;
					wr_idx = addr_q[AW-1:0];
					sts_d  = STS_DONE;
				end
			end
			KIND_RESTART: begin
				pc_d  = '0;
				acc_d = '0;
				run_d = 1'b1;
				sts_d = STS_DONE;
			end
			KIND_OVERRUN: begin
				run_d = 1'b0;
				sts_d = STS_PC_OVERRUN;
			end
			KIND_EXEC: begin
				sts_d = STS_EXECUTED;
				pc_d  = pc_q + 7'd1;
				unique case (op_q)
					OP_READ: begin
						wr_en = opnd_ok_q;
					end
					OP_WRITE: begin
						outv_d = opw;
						sts_d  = STS_WROTE;
					end
					OP_LOAD:  acc_d = opw;
					OP_STORE: begin
						wr_en   = opnd_ok_q;
						wr_data = acc_q;
					end
					OP_ADD:   acc_d = sum_sat;
					OP_HALT: begin
						run_d = 1'b0;
						sts_d = STS_HALTED;
						pc_d  = pc_q;
					end
					default: begin
						run_d = 1'b0;
						sts_d = STS_BAD_OP;
						pc_d  = pc_q;
					end
				endcase
			end
			default: sts_d = STS_IGNORED;
		endcase
		if (!cmd.exec)
			wr_en = 1'b0;
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_idx] <= wr_data;
		if (rd_en)
			rd_data_q <= mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en)
				valid_q[wr_idx] <= 1'b1;
			if (rd_en)
				rd_valid_q <= valid_q[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= '0;
			acc_q <= '0;
			run_q <= 1'b1;
			op_q  <= '0;
		end else begin
			if (cmd.fetch)
				op_q <= opc;
			if (cmd.exec) begin
				pc_q  <= pc_d;
				acc_q <= acc_d;
				run_q <= run_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			addr_q <= address;
			val_q  <= val_sat;
		end
		if (cmd.fetch) begin
			opnd_q    <= rem;
			opnd_ok_q <= (rem < DEPTH);
		end
		if (cmd.exec) begin
			status_q <= sts_d;
			outv_q   <= outv_d;
		end
	end

	assign sts.running     = run_q;
	assign sts.pc_ovf      = (pc_q >= DEPTH);
	assign status          = status_q;
	assign out_value       = outv_q;
	assign program_counter = pc_q;
	assign acc_value       = acc_q;
	assign last_opcode     = op_q;

`ifndef SYNTHESIS
	a_pc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= DEPTH)
		else $error("program counter beyond store");
	a_acc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_q <= WORD_MAX) && (acc_q >= WORD_MIN))
		else $error("accumulator out of word range");
	a_stop_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && (cmd.kind == KIND_OVERRUN) |=> !run_q)
		else $error("machine still running after pc overrun");
`endif

endmodule
